// File: hdl/slr_pkg.sv
`timescale 1ns / 1ps

package slr_pkg;

   // command codes on req_cmd
   localparam logic CMD_REQUEST = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_WINDOW_SCALE = 2'd0;
   localparam logic [1:0] CSR_WINDOW_TRIM  = 2'd1;
   localparam logic [1:0] CSR_REPEAT_SCALE = 2'd2;

   // configuration reset values
   localparam logic [3:0] WINDOW_SCALE_RST = 4'd3;
   localparam logic [7:0] WINDOW_TRIM_RST  = 8'd3;
   localparam logic [3:0] REPEAT_SCALE_RST = 4'd6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } slr_state_type;

   // shared bus broadcast to every slot cell
   typedef struct packed {
      logic        wr;
      logic [4:0]  slot;
      logic [31:0] now;
      logic [3:0]  wscale;
      logic [7:0]  trim;
      logic [3:0]  rscale;
   } slr_bus_type;

   // retrigger length per slot, zero past the table
   function automatic logic [7:0] slot_len(input int unsigned idx);
      logic [7:0] len;
      case (idx)
         0:  len = 8'd40;
         1:  len = 8'd60;
         2:  len = 8'd60;
         3:  len = 8'd60;
         4:  len = 8'd60;
         5:  len = 8'd60;
         6:  len = 8'd40;
         7:  len = 8'd36;
         8:  len = 8'd36;
         9:  len = 8'd16;
         10: len = 8'd16;
         11: len = 8'd16;
         12: len = 8'd20;
         13: len = 8'd20;
         14: len = 8'd12;
         15: len = 8'd12;
         16: len = 8'd40;
         17: len = 8'd40;
         18: len = 8'd40;
         19: len = 8'd40;
         20: len = 8'd40;
         21: len = 8'd20;
         22: len = 8'd40;
         23: len = 8'd40;
         24: len = 8'd36;
         25: len = 8'd18;
         26: len = 8'd36;
         27: len = 8'd60;
         28: len = 8'd200;
         29: len = 8'd60;
         30: len = 8'd60;
         31: len = 8'd50;
         default: len = 8'd0;
      endcase
      return len;
   endfunction

   // wrap-safe time compare: t is reached when now - t is not negative
   function automatic logic reached(input logic [31:0] now, input logic [31:0] t);
      logic [31:0] diff;
      diff = now - t;
      return ~diff[31];
   endfunction

endpackage

// File: hdl/slr_cell.sv
`timescale 1ns / 1ps

module slr_cell #(
   parameter int IDX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  slr_pkg::slr_bus_type bus,
   input  logic               token_in,
   output logic               token_out,
   output logic               play
);
   import slr_pkg::*;

   localparam logic [7:0] LEN = slot_len(IDX);

   logic        token_ff;
   logic        active_ff, active_in;
   logic [31:0] wend_ff, wend_in;
   logic [31:0] next_ff, next_in;
   logic        hit;
   logic [11:0] win_len;
   logic [11:0] rep_len;

   assign hit     = bus.wr && (6'(bus.slot) == 6'(IDX));
   assign win_len = 12'(LEN) * 12'(bus.wscale);
   assign rep_len = 12'(LEN) * 12'(bus.rscale);

   // request opens or extends the window; service when holding the token
   always_comb begin
      active_in = active_ff;
      wend_in   = wend_ff;
      next_in   = next_ff;
      play      = 1'b0;
      if (hit) begin
         if (!active_ff) begin
            next_in = bus.now;
         end
         wend_in   = bus.now + 32'(win_len) - 32'(bus.trim);
         active_in = 1'b1;
      end else if (token_ff && active_ff) begin
         if (reached(bus.now, wend_ff)) begin
            active_in = 1'b0;
         end else if (reached(bus.now, next_ff)) begin
            play    = 1'b1;
            next_in = bus.now + 32'(rep_len);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff  <= 1'b0;
         active_ff <= 1'b0;
      end else begin
         token_ff  <= token_in;
         active_ff <= active_in;
      end
   end

   // slot times
   always_ff @(posedge clock) begin
      wend_ff <= wend_in;
      next_ff <= next_in;
   end

   assign token_out = token_ff;

endmodule

// File: hdl/slr_ctrl.sv
`timescale 1ns / 1ps

module slr_ctrl #(
   parameter int SLOTS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       go,
   input  logic       any_play,
   input  logic       last_cell,
   output logic       busy,
   output logic       rsp_valid,
   output logic [4:0] rsp_play_slot,
   output logic       rsp_last
);
   import slr_pkg::*;

   localparam int CW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   slr_state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [4:0]    pend_slot_ff, pend_slot_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [4:0]    rsp_slot_ff, rsp_slot_in;
   logic          rsp_last_ff, rsp_last_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (last_cell) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // slot counter, pending play and result register
   always_comb begin
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      rsp_valid_in  = 1'b0;
      rsp_slot_in   = rsp_slot_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in        = '0;
            pend_valid_in = 1'b0;
         end
         ST_WALK: begin
            cnt_in = cnt_ff + CW'(1);
            if (any_play) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_slot_in  = pend_slot_ff;
                  rsp_last_in  = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_slot_in  = 5'(cnt_ff);
            end
         end
         ST_DONE: begin
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = pend_slot_ff;
               rsp_last_in  = 1'b1;
            end
            pend_valid_in = 1'b0;
         end
         default: begin
            pend_valid_in = 1'b0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      pend_slot_ff <= pend_slot_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_play_slot = rsp_slot_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// File: hdl/sound_retrigger_limiter.sv
`timescale 1ns / 1ps

// channel   ports                                           handshake
// input     req_cmd, req_slot_index, req_now_ms             start & !busy
// result    rsp_play_slot, rsp_last                         rsp_valid, one cycle
// config    csr_index, csr_wdata                            csr_valid & csr_ready
//
// An item is taken only while busy is low; busy then stays high while a token walks
// the row of slot cells one cell per cycle and the done state flushes the held play.
// A play is held until the next play or the flush, then passes through the result
// register, so the final one, marked by rsp_last, comes in the first cycle with
// busy low. A request on a slot past SLOTS is taken and ignored. Reset is synchronous,
// every slot starts idle.

module sound_retrigger_limiter #(
   parameter int SLOTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [4:0]  req_slot_index,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   output logic [4:0]  rsp_play_slot,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import slr_pkg::*;

   logic [3:0]  wscale_ff;
   logic [7:0]  trim_ff;
   logic [3:0]  rscale_ff;
   logic [31:0] now_ff;
   logic        accept;
   logic        go;
   logic        is_req;
   slr_bus_type bus;
   logic [SLOTS-1:0] tok;
   logic [SLOTS-1:0] play_vec;

   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign is_req    = (req_cmd == CMD_REQUEST);
   assign go        = accept && (!is_req || (7'(req_slot_index) < 7'(SLOTS)));

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wscale_ff <= WINDOW_SCALE_RST;
         trim_ff   <= WINDOW_TRIM_RST;
         rscale_ff <= REPEAT_SCALE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WINDOW_SCALE: wscale_ff <= csr_wdata[3:0];
            CSR_WINDOW_TRIM:  trim_ff   <= csr_wdata;
            CSR_REPEAT_SCALE: rscale_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // item time held for the walk
   always_ff @(posedge clock) begin
      if (accept) begin
         now_ff <= req_now_ms;
      end
   end

   // broadcast to the cells
   always_comb begin
      bus.wr     = go && is_req;
      bus.slot   = req_slot_index;
      bus.now    = busy ? now_ff : req_now_ms;
      bus.wscale = wscale_ff;
      bus.trim   = trim_ff;
      bus.rscale = rscale_ff;
   end

   // row of slot cells passing the service token
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      logic tin;
      if (i == 0) begin : g_head
         assign tin = go;
      end else begin : g_link
         assign tin = tok[i-1];
      end
      slr_cell #(
         .IDX(i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .bus      (bus),
         .token_in (tin),
         .token_out(tok[i]),
         .play     (play_vec[i])
      );
   end

   slr_ctrl #(
      .SLOTS(SLOTS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .go           (go),
      .any_play     (|play_vec),
      .last_cell    (tok[SLOTS-1]),
      .busy         (busy),
      .rsp_valid    (rsp_valid),
      .rsp_play_slot(rsp_play_slot),
      .rsp_last     (rsp_last)
   );

endmodule

// File: test/sound_retrigger_limiter_tb.sv
`timescale 1ns / 1ps

module sound_retrigger_limiter_tb;
   import slr_pkg::*;

   localparam int SLOTS = 32;
   // settle time after the last item: slot walk plus flush, with margin
   localparam int SETTLE_CYCLES = SLOTS + 8;
   // register index with no register behind it
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   // retrigger length per slot, slot 31 in the top byte
   localparam logic [SLOTS*8-1:0] LEN_TABLE = {
      8'd50, 8'd60, 8'd60, 8'd200, 8'd60, 8'd36, 8'd18, 8'd36,
      8'd40, 8'd40, 8'd20, 8'd40, 8'd40, 8'd40, 8'd40, 8'd40,
      8'd12, 8'd12, 8'd20, 8'd20, 8'd16, 8'd16, 8'd16, 8'd36,
      8'd36, 8'd40, 8'd60, 8'd60, 8'd60, 8'd60, 8'd60, 8'd40 };

   typedef struct packed {
      logic [4:0] slot;
      logic       last;
   } play_rec_type;

   typedef struct packed {
      logic        cmd;
      logic [4:0]  slot;
      logic [31:0] now;
      logic        hold;
   } trigger_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_cmd = CMD_TICK;
   logic [4:0]  req_slot_index = 5'd0;
   logic [31:0] req_now_ms = 32'd0;
   logic        rsp_valid;
   logic [4:0]  rsp_play_slot;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_WINDOW_SCALE;
   logic [7:0]  csr_wdata = 8'd0;

   // limiter state as the testbench sees it
   logic [31:0] win_end [SLOTS];
   logic [31:0] next_due [SLOTS];
   logic        slot_on [SLOTS];
   logic [3:0]  cfg_wscale;
   logic [7:0]  cfg_trim;
   logic [3:0]  cfg_rscale;

   trigger_item_type pending_items[$];
   play_rec_type     expected_plays[$];
   logic             drained = 1'b1;
   logic [31:0]      traffic_now;
   int items_added = 0;
   int items_taken = 0;
   int requests_taken = 0;
   int ticks_taken = 0;
   int plays_checked = 0;
   int max_burst = 0;
   int csr_writes = 0;
   int error_count = 0;

   sound_retrigger_limiter #(.SLOTS(SLOTS)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_slot_index(req_slot_index),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid),
      .rsp_play_slot(rsp_play_slot),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // clock
   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   // a time counts as reached once now - t is not negative
   function automatic logic time_due(input logic [31:0] now, input logic [31:0] t);
      return $signed(now - t) >= 0;
   endfunction

   // apply one item to the state and queue the plays it causes
   function automatic void retrigger_step(input logic cmd, input logic [4:0] slot,
                                          input logic [31:0] now);
      logic [31:0]  len;
      logic [4:0]   hit_slot [SLOTS];
      int           n_hits;
      play_rec_type rec;
      n_hits = 0;
      if (cmd == CMD_REQUEST) begin
         len = {24'd0, LEN_TABLE[slot*8 +: 8]};
         if (!slot_on[slot]) next_due[slot] = now;
         win_end[slot] = now + len * {28'd0, cfg_wscale} - {24'd0, cfg_trim};
         slot_on[slot] = 1'b1;
      end
      // service in index order
      for (int i = 0; i < SLOTS; i++) begin
         len = {24'd0, LEN_TABLE[i*8 +: 8]};
         if (slot_on[i]) begin
            if (time_due(now, win_end[i])) begin
               slot_on[i] = 1'b0;
            end else if (time_due(now, next_due[i])) begin
               hit_slot[n_hits] = 5'(i);
               n_hits++;
               next_due[i] = now + len * {28'd0, cfg_rscale};
            end
         end
      end
      for (int k = 0; k < n_hits; k++) begin
         rec.slot = hit_slot[k];
         rec.last = (k == n_hits - 1);
         expected_plays.push_back(rec);
      end
      if (n_hits > max_burst) max_burst = n_hits;
   endfunction

   // driver: presents queued items, idles at random, holds drain items
   always @(posedge clock) begin : item_driver
      trigger_item_type nxt;
      logic             send_ok;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            retrigger_step(req_cmd, req_slot_index, req_now_ms);
            items_taken++;
            if (req_cmd == CMD_REQUEST) requests_taken++;
            else ticks_taken++;
         end
         if (!start || !busy) begin
            send_ok = pending_items.size() != 0;
            if (send_ok && pending_items[0].hold)
               send_ok = !start && !busy && drained;
            // a long stretch with no idling in the middle of the run
            if (send_ok && !(items_taken >= 200 && items_taken < 300)
                && $urandom_range(0, 99) < 6)
               send_ok = 1'b0;
            if (send_ok) begin
               nxt = pending_items.pop_front();
               start <= 1'b1;
               req_cmd <= nxt.cmd;
               req_slot_index <= nxt.slot;
               req_now_ms <= nxt.now;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: check every play against the oldest expectation
   always @(posedge clock) begin : play_monitor
      play_rec_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_plays.size() == 0) begin
               report_mismatch($sformatf("unexpected play slot %0d last %0b",
                                         rsp_play_slot, rsp_last));
            end else begin
               want = expected_plays.pop_front();
               plays_checked++;
               if (rsp_play_slot !== want.slot)
                  report_mismatch($sformatf("play_slot %0d, expected %0d",
                                            rsp_play_slot, want.slot));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b on slot %0d, expected %0b",
                                            rsp_last, want.slot, want.last));
            end
         end
         drained <= (expected_plays.size() == 0);
      end
   end

   task automatic add_item(input logic cmd, input logic [4:0] slot, input logic [31:0] now,
                           input logic hold);
      trigger_item_type it;
      it.cmd = cmd;
      it.slot = slot;
      it.now = now;
      it.hold = hold;
      pending_items.push_back(it);
      items_added++;
   endtask

   // wait until every item is taken, every play seen, then let the block settle
   task automatic wait_quiet();
      do @(posedge clock);
      while (items_taken != items_added || busy || expected_plays.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one register write; caller drops csr_valid after the batch
   task automatic csr_write(input logic [1:0] idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock);
      while (!csr_ready);
      csr_writes++;
      case (idx)
         CSR_WINDOW_SCALE: cfg_wscale = data[3:0];
         CSR_WINDOW_TRIM:  cfg_trim = data;
         CSR_REPEAT_SCALE: cfg_rscale = data[3:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [7:0] ws, input logic [7:0] trim,
                             input logic [7:0] rs);
      wait_quiet();
      csr_write(CSR_WINDOW_SCALE, ws);
      csr_write(CSR_WINDOW_TRIM, trim);
      csr_write(CSR_REPEAT_SCALE, rs);
      csr_write(CSR_UNUSED, 8'($urandom));
      csr_valid <= 1'b0;
   endtask

   // mostly steady time with requests and ticks, some jumps and backward steps
   task automatic gen_traffic(input int n);
      logic       cmd;
      logic [4:0] slot;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1) == 0) traffic_now = $urandom();
            else traffic_now = traffic_now - $urandom_range(1, 500);
         end else if ($urandom_range(0, 7) == 0) begin
            traffic_now = traffic_now + $urandom_range(100, 2000);
         end else begin
            traffic_now = traffic_now + $urandom_range(0, 40);
         end
         cmd = ($urandom_range(0, 99) < 40) ? CMD_REQUEST : CMD_TICK;
         // half of the requests go to a few hot slots so windows get extended
         slot = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 3)) : 5'($urandom());
         add_item(cmd, slot, traffic_now, $urandom_range(0, 39) == 0);
      end
   endtask

   // stimulus
   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         win_end[i] = 32'd0;
         next_due[i] = 32'd0;
         slot_on[i] = 1'b0;
      end
      cfg_wscale = WINDOW_SCALE_RST;
      cfg_trim = WINDOW_TRIM_RST;
      cfg_rscale = REPEAT_SCALE_RST;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: first play, window expiry, wrap of the time, extension, order
      add_item(CMD_REQUEST, 5'd0, 32'd0, 1'b0);
      add_item(CMD_TICK, 5'd31, 32'd100, 1'b0);
      add_item(CMD_TICK, 5'd0, 32'd117, 1'b0);
      add_item(CMD_REQUEST, 5'd31, 32'hFFFF_FFF0, 1'b0);
      add_item(CMD_REQUEST, 5'd28, 32'hFFFF_FFF8, 1'b0);
      add_item(CMD_REQUEST, 5'd28, 32'h0000_0010, 1'b1);
      add_item(CMD_TICK, 5'd0, 32'h0000_0200, 1'b0);
      add_item(CMD_TICK, 5'd0, 32'h0000_0264, 1'b0);
      add_item(CMD_TICK, 5'd0, 32'h0000_0265, 1'b0);
      add_item(CMD_REQUEST, 5'd14, 32'h7FFF_FFF0, 1'b0);
      add_item(CMD_REQUEST, 5'd15, 32'h7FFF_FFF0, 1'b0);
      add_item(CMD_REQUEST, 5'd9, 32'h7FFF_FFF8, 1'b0);
      add_item(CMD_TICK, 5'd21, 32'h8000_0038, 1'b0);
      add_item(CMD_TICK, 5'd10, 32'h8000_0040, 1'b0);
      add_item(CMD_REQUEST, 5'd14, 32'h8000_0060, 1'b0);
      add_item(CMD_TICK, 5'd0, 32'h8000_0200, 1'b1);
      // time running backward by half the range counts as not reached
      add_item(CMD_REQUEST, 5'd1, 32'h1234_5678, 1'b0);
      add_item(CMD_TICK, 5'd0, 32'h9234_5678, 1'b0);
      add_item(CMD_TICK, 5'd0, 32'h1234_5700, 1'b0);
      add_item(CMD_TICK, 5'd0, 32'hFFFF_FFFF, 1'b0);

      // widest windows and repeats, no trim
      set_config(8'h0F, 8'h00, 8'hFF);
      traffic_now = $urandom();
      gen_traffic(90);

      // every window empty; zero repeat scale
      set_config(8'hF0, 8'hFF, 8'h00);
      traffic_now = 32'hFFFF_FF00;
      gen_traffic(20);

      // short windows with a play on every service: all slots at once
      set_config(8'h01, 8'h00, 8'h00);
      traffic_now = 32'h7FFF_FF80;
      for (int s = 0; s < SLOTS; s++) add_item(CMD_REQUEST, 5'(s), traffic_now, 1'b0);
      add_item(CMD_TICK, 5'd7, traffic_now + 32'd1, 1'b0);
      gen_traffic(60);

      // trim that empties the short windows but not the longest
      set_config(8'h01, 8'd100, 8'h01);
      traffic_now = $urandom();
      gen_traffic(80);

      // random settings
      for (int p = 0; p < 3; p++) begin
         set_config({4'($urandom), 4'($urandom_range(0, 15))}, 8'($urandom),
                    {4'($urandom), 4'($urandom_range(0, 15))});
         traffic_now = $urandom();
         gen_traffic(60);
      end

      wait_quiet();
      $display("covered %0d items (%0d requests, %0d ticks) over %0d register writes",
               items_taken, requests_taken, ticks_taken, csr_writes);
      $display("checked %0d plays, up to %0d from a single item", plays_checked, max_burst);
      if (error_count == 0 && expected_plays.size() == 0) begin
         $display("sound_retrigger_limiter_tb: PASS");
      end else begin
         if (expected_plays.size() != 0)
            $display("ERROR: %0d expected plays never came", expected_plays.size());
         $display("sound_retrigger_limiter_tb: FAIL");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("ERROR: run limit reached, %0d of %0d items taken", items_taken, items_added);
      $display("sound_retrigger_limiter_tb: FAIL");
      $finish;
   end

endmodule
